/* rtl/core/fixed_block_pool_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Concurrent check wrappers used by the allocator's assertions.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// cond holds at every clock edge outside reset
`define FBPA_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fbpa: invariant broken");

// cons holds in the cycle after ante
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa: next-cycle check failed");

`endif

/* rtl/core/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, operation and register codes, word and divider types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int ADDR_W       = 20;
    localparam int SIZE_W       = 16;
    localparam int FREE_W       = 9;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 20;
    localparam int HEADER_BYTES = 16;
    localparam int STEP_W       = SIZE_W + 1;
    // header size bounds the slot step from below, so the top quotient bits are zero
    localparam int QUO_W        = ADDR_W - $clog2(HEADER_BYTES);

    localparam logic [SIZE_W-1:0] MIN_PAGE   = 16'd8;
    localparam logic [SIZE_W-1:0] PAGE_RESET = 16'd8;

    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REINIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES     = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] req_size;
        logic              null_ptr;
        logic [ADDR_W-1:0] addr_offset;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] block_offset;
        logic [FREE_W-1:0] free_slots;
        logic [SIZE_W-1:0] next_size;
    } t_rsp;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
        logic [STEP_W-1:0] rem;
    } t_div_res;

endpackage

/* rtl/core/fbpa_if.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator channels
// Valid/ready request and response channels with their payload words.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
    logic           valid;
    logic           ready;
    fbpa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fbpa_rsp_if;
    logic           valid;
    logic           ready;
    fbpa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/fbpa_slot_ram.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator slot memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fbpa_slot_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9,
    localparam int IW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [IW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/fbpa_div.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator divider
// Restoring divider, one quotient bit per cycle, for offsets over slot step.
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_dividend,
    input  logic [fbpa_pkg::STEP_W-1:0]       i_divisor,
    output fbpa_pkg::t_div_res                o_res
);

    localparam int AW    = fbpa_pkg::ADDR_W;
    localparam int SW    = fbpa_pkg::STEP_W;
    localparam int QW    = fbpa_pkg::QUO_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_div;
    logic [QW-1:0]    r_dq;
    logic [SW:0]      w_sh;
    logic [SW:0]      w_trial;
    logic             w_ge;

    assign w_sh    = {r_rem, r_dq[QW-1]};
    assign w_ge    = w_sh >= {1'b0, r_div};
    assign w_trial = w_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SW'(i_dividend[AW-1:QW]);
            r_dq  <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= w_ge ? w_trial[SW-1:0] : w_sh[SW-1:0];
            r_dq  <= {r_dq[QW-2:0], w_ge};
        end
    end

    assign o_res.done = r_busy && (r_cnt == '0);
    assign o_res.quo  = r_dq;
    assign o_res.rem  = r_rem;

endmodule

/* rtl/core/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out equal slots of a region: each slot is a 16-byte header plus a
// payload of page_bytes, and free slots sit on a linked free list held in an
// on-chip slot memory (link and used mark per slot). One word in gives one
// word out. An acquire does one read-modify-write of the slot memory. A
// non-null release that lies inside the region runs through the 16-step
// serial divider that finds the slot index and checks the slot boundary;
// one that lands on a boundary below the fresh-slot pointer then does a
// read-modify-write. A reinitialise runs through the same divider to count
// the slots. A null release and any request rejected before the divider are
// answered from the idle state, without the divider. No clearing
// pass is needed after reset or reinitialise: slots are handed out from a
// fresh-slot pointer until first release, and only entries below it are read.
// A result waiting at the output does not stop the next word being accepted;
// a second finished result is held inside and blocks the input until the
// output drains.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    fbpa_req_if.sink                           i_req,
    fbpa_rsp_if.source                         o_rsp
);

    localparam int AW    = fbpa_pkg::ADDR_W;
    localparam int PW    = fbpa_pkg::SIZE_W;
    localparam int STW   = fbpa_pkg::STEP_W;
    localparam int QW    = fbpa_pkg::QUO_W;
    localparam int FW    = fbpa_pkg::FREE_W;
    localparam int SW    = $clog2(MAX_SLOTS);
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int MW    = SW + 1;
    localparam int CMP_W = QW + 1;

    localparam logic [AW-1:0]  HDR_OFF  = AW'(fbpa_pkg::HEADER_BYTES);
    localparam logic [STW-1:0] HDR_STEP = STW'(fbpa_pkg::HEADER_BYTES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_present;
    logic [AW-1:0]                 r_region;
    logic [PW-1:0]                 r_page;
    logic [SW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_fresh, n_fresh;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_stack, n_stack;
    logic [CW-1:0]                 r_free_total, n_free_total;
    logic [fbpa_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [SW-1:0]                 r_slot, n_slot;
    logic [AW-1:0]                 r_prod, n_prod;
    fbpa_pkg::t_rsp                r_res;
    logic                          r_out_valid;
    fbpa_pkg::t_rsp                r_out;

    logic [STW-1:0]                w_step;
    logic                          w_stack_any;
    logic [SW-1:0]                 w_eff_head;
    logic [AW-1:0]                 w_prod;
    logic [AW-1:0]                 w_hdr;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_fin;
    logic                          w_res_ok;
    logic [AW-1:0]                 w_res_off;
    fbpa_pkg::t_rsp                w_res;
    logic                          w_load;
    fbpa_pkg::t_rsp                w_load_data;
    logic                          w_acq_rd;

    logic                          w_div_start;
    logic [AW-1:0]                 w_dividend;
    fbpa_pkg::t_div_res            w_div;

    logic                          w_ram_we;
    logic [SW-1:0]                 w_ram_waddr;
    logic [MW-1:0]                 w_ram_wdata;
    logic [SW-1:0]                 w_ram_raddr;
    logic [MW-1:0]                 w_ram_rdata;
    logic                          w_rd_used;
    logic [SW-1:0]                 w_rd_link;

    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_step),
        .o_res      (w_div)
    );

    fbpa_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (MW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign w_step      = {1'b0, r_page} + HDR_STEP;
    assign w_stack_any = r_stack != '0;
    assign w_eff_head  = w_stack_any ? r_head : r_fresh[SW-1:0];
    assign w_prod      = AW'(w_eff_head) * AW'(w_step);
    assign w_hdr       = i_req.data.addr_offset - HDR_OFF;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_rd_used   = w_ram_rdata[MW-1];
    assign w_rd_link   = w_ram_rdata[SW-1:0];
    assign w_acq_rd    = (r_state == S_READ) && (r_kind == fbpa_pkg::KIND_ACQUIRE);

    assign i_req.ready = r_state == S_IDLE;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_fresh      = r_fresh;
        n_count      = r_count;
        n_stack      = r_stack;
        n_free_total = r_free_total;
        n_kind       = r_kind;
        n_slot       = r_slot;
        n_prod       = r_prod;
        w_fin        = 1'b0;
        w_res_ok     = 1'b0;
        w_res_off    = '0;
        w_div_start  = 1'b0;
        w_dividend   = w_hdr;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_slot;
        w_ram_wdata  = {1'b1, w_rd_link};
        w_ram_raddr  = w_eff_head;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind = i_req.data.kind;
                    n_slot = w_eff_head;
                    n_prod = w_prod;
                    case (i_req.data.kind)
                        fbpa_pkg::KIND_ACQUIRE: begin
                            if (i_req.data.req_size != '0 && i_req.data.req_size <= r_page
                                && r_free_total != '0) begin
                                n_state = S_READ;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        fbpa_pkg::KIND_RELEASE: begin
                            if (i_req.data.null_ptr) begin
                                w_fin    = 1'b1;
                                w_res_ok = 1'b1;
                            end else if (r_present && i_req.data.addr_offset >= HDR_OFF
                                         && w_hdr < r_region) begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        fbpa_pkg::KIND_REINIT: begin
                            if (r_present && r_page >= fbpa_pkg::MIN_PAGE) begin
                                w_div_start = 1'b1;
                                w_dividend  = r_region;
                                n_state     = S_DIV;
                            end else begin
                                w_fin = 1'b1;
                            end
                        end
                        default: begin
                            w_fin = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    if (r_kind == fbpa_pkg::KIND_REINIT) begin
                        if (CMP_W'(w_div.quo) > CMP_W'(MAX_SLOTS)) begin
                            n_count      = CW'(MAX_SLOTS);
                            n_free_total = CW'(MAX_SLOTS);
                        end else begin
                            n_count      = CW'(w_div.quo);
                            n_free_total = CW'(w_div.quo);
                        end
                        n_fresh  = '0;
                        n_stack  = '0;
                        n_head   = '0;
                        w_fin    = 1'b1;
                        w_res_ok = 1'b1;
                    end else begin
                        w_ram_raddr = w_div.quo[SW-1:0];
                        n_slot      = w_div.quo[SW-1:0];
                        if (w_div.rem == '0 && CMP_W'(w_div.quo) < CMP_W'(r_fresh)) begin
                            n_state = S_READ;
                        end else begin
                            w_fin = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                w_fin = 1'b1;
                if (r_kind == fbpa_pkg::KIND_ACQUIRE) begin
                    w_ram_we     = 1'b1;
                    w_ram_wdata  = {1'b1, w_rd_link};
                    if (w_stack_any) begin
                        n_head  = w_rd_link;
                        n_stack = r_stack - CW'(1);
                    end else begin
                        n_fresh = r_fresh + CW'(1);
                    end
                    n_free_total = r_free_total - CW'(1);
                    w_res_ok     = 1'b1;
                    w_res_off    = r_prod + HDR_OFF;
                end else if (w_rd_used) begin
                    w_ram_we     = 1'b1;
                    w_ram_wdata  = {1'b0, w_eff_head};
                    n_head       = r_slot;
                    n_stack      = r_stack + CW'(1);
                    n_free_total = r_free_total + CW'(1);
                    w_res_ok     = 1'b1;
                end
            end
            S_OUT: begin
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        w_res.ok           = w_res_ok;
        w_res.block_offset = w_res_off;
        w_res.free_slots   = FW'(n_free_total);
        w_res.next_size    = (n_free_total != '0) ? r_page : '0;

        w_load      = 1'b0;
        w_load_data = w_res;
        if (w_fin) begin
            if (w_out_free) begin
                w_load  = 1'b1;
                n_state = S_IDLE;
            end else begin
                n_state = S_OUT;
            end
        end
        if (r_state == S_OUT && w_out_free) begin
            w_load      = 1'b1;
            w_load_data = r_res;
            n_state     = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_present    <= 1'b0;
            r_region     <= '0;
            r_page       <= fbpa_pkg::PAGE_RESET;
            r_head       <= '0;
            r_fresh      <= '0;
            r_count      <= '0;
            r_stack      <= '0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_fresh      <= n_fresh;
            r_count      <= n_count;
            r_stack      <= n_stack;
            r_free_total <= n_free_total;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fbpa_pkg::CFG_REGION_PRESENT: r_present <= i_cfg_data[0];
                    fbpa_pkg::CFG_REGION_BYTES:   r_region  <= i_cfg_data[AW-1:0];
                    fbpa_pkg::CFG_PAGE_BYTES:     r_page    <= i_cfg_data[PW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_slot <= n_slot;
        r_prod <= n_prod;
        if (w_fin) begin
            r_res <= w_res;
        end
        if (w_load) begin
            r_out <= w_load_data;
        end
    end

    `FBPA_ASSERT_HOLDS(a_free_split, i_clk, i_rst_n, r_free_total == r_stack + (r_count - r_fresh))
    `FBPA_ASSERT_HOLDS(a_fresh_bound, i_clk, i_rst_n, r_fresh <= r_count)
    `FBPA_ASSERT_NEXT(a_acquire_dec, i_clk, i_rst_n, w_acq_rd, r_free_total == $past(r_free_total) - CW'(1))

endmodule
